@@ rtl/swfd_pkg.sv @@
// Shared types and constants for the string wave finite-difference step block.
`default_nettype none

package swfd_pkg;

    // Item kinds carried in tuser
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_LOAD  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_COEF_CENTER   = 2'd0;
    localparam logic [1:0] REG_COEF_NEIGHBOR = 2'd1;
    localparam logic [1:0] REG_NUM_SEGMENTS  = 2'd2;

    localparam int APB_AW     = 4;
    localparam int APB_DW     = 32;
    localparam int KIND_W     = 2;
    localparam int IDX_W      = 10;
    localparam int DATA_W     = 32;
    localparam int COEF_W     = 32;
    localparam int NSEG_W     = 11;
    localparam int IN_TDATA_W = 48;
    localparam int OUT_TDATA_W = 64;
    localparam int MIN_SEGS   = 5;
    localparam int NSEG_RESET = 1024;

    // Arithmetic widths: Q12.52 products, exact three-term sum, Q8.24 result
    localparam int PROD_W     = 64;
    localparam int PSUM_W     = PROD_W + 1;
    localparam int SUM_W      = PROD_W + 2;
    localparam int FRAC_SHIFT = 28;
    localparam int RND_W      = SUM_W - FRAC_SHIFT;
    localparam int DIFF_W     = RND_W + 1;

    typedef struct packed {
        logic tick_start;
        logic clear_start;
        logic load;
        logic swap;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic busy;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

@@ rtl/string_wave_fdtd_step.sv @@
// Top level: register port, segment-count clamp, controller and datapath.
//
//  Channel   Dir  Handshake                 Contents
//  s_axis    in   s_axis_tvalid/tready      tuser: kind; tdata: point_index, point_value
//  m_axis    out  m_axis_tvalid/tready      tdata: left_sample, right_sample
//  apb       in   psel/penable/pwrite/pready coef_center, coef_neighbor, num_segments
//
// A tick (N = active segment count) makes one pass of the read port over
// points 1 .. N-2, then four pipeline stages of read data/multiply/add/round.
// A load writes one point; a clear zeroes both levels, one entry per cycle.
// After reset a clearing pass over all MAX_SEGMENTS entries runs before items are taken.
// A finished result waits in the output register; the next tick stalls only at
// its hand-off while that register is still full.
`default_nettype none

module string_wave_fdtd_step #(
    parameter int MAX_SEGMENTS = 1024
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // stream in
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // [9:0] point_index, [41:10] point_value, [47:42] zero
    input  wire logic [swfd_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // [1:0] kind
    input  wire logic [swfd_pkg::KIND_W-1:0]           s_axis_tuser,
    // stream out
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // [31:0] left_sample, [63:32] right_sample
    output logic [swfd_pkg::OUT_TDATA_W-1:0]           m_axis_tdata,
    // register port
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [swfd_pkg::APB_AW-1:0]           paddr,
    input  wire logic [swfd_pkg::APB_DW-1:0]           pwdata,
    output logic [swfd_pkg::APB_DW-1:0]                prdata,
    output logic                                       pready
);

    localparam int AW = $clog2(MAX_SEGMENTS);
    localparam int NW = (AW + 1 > swfd_pkg::NSEG_W) ? AW + 1 : swfd_pkg::NSEG_W;

    logic signed [swfd_pkg::COEF_W-1:0] r_coef_center;
    logic signed [swfd_pkg::COEF_W-1:0] r_coef_neighbor;
    logic [swfd_pkg::NSEG_W-1:0]        r_num_segments;

    logic                               w_wr;
    logic [1:0]                         w_reg_idx;
    logic [NW-1:0]                      w_nseg_ext;
    logic [NW-1:0]                      w_nact;
    logic [NW-1:0]                      w_last_full;
    logic [NW-1:0]                      w_rpos_full;
    logic                               w_accept;
    logic [swfd_pkg::DATA_W-1:0]        w_left;
    logic [swfd_pkg::DATA_W-1:0]        w_right;
    swfd_pkg::t_dp_cmd                  w_cmd;
    swfd_pkg::t_dp_sts                  w_sts;

    // ---------------- register port ----------------
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[3:2];
    assign w_wr      = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_center   <= '0;
            r_coef_neighbor <= '0;
            r_num_segments  <= swfd_pkg::NSEG_W'(swfd_pkg::NSEG_RESET);
        end else if (w_wr) begin
            case (w_reg_idx)
                swfd_pkg::REG_COEF_CENTER:   r_coef_center   <= pwdata;
                swfd_pkg::REG_COEF_NEIGHBOR: r_coef_neighbor <= pwdata;
                swfd_pkg::REG_NUM_SEGMENTS:  r_num_segments  <= pwdata[swfd_pkg::NSEG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            swfd_pkg::REG_COEF_CENTER:   prdata = r_coef_center;
            swfd_pkg::REG_COEF_NEIGHBOR: prdata = r_coef_neighbor;
            swfd_pkg::REG_NUM_SEGMENTS:  prdata = swfd_pkg::APB_DW'(r_num_segments);
            default:                     prdata = '0;
        endcase
    end

    // ---------------- segment count clamp ----------------
    assign w_nseg_ext = NW'(r_num_segments);

    always_comb begin
        if (w_nseg_ext < NW'(swfd_pkg::MIN_SEGS)) begin
            w_nact = NW'(swfd_pkg::MIN_SEGS);
        end else if (w_nseg_ext > NW'(MAX_SEGMENTS)) begin
            w_nact = NW'(MAX_SEGMENTS);
        end else begin
            w_nact = w_nseg_ext;
        end
    end

    assign w_last_full = w_nact - NW'(2);
    assign w_rpos_full = w_nact - NW'(4);

    // ---------------- controller / datapath ----------------
    assign w_accept = s_axis_tvalid && s_axis_tready;

    swfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_kind  (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    swfd_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .AW           (AW)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_accept        (w_accept),
        .i_point_index   (s_axis_tdata[swfd_pkg::IDX_W-1:0]),
        .i_point_value   (s_axis_tdata[swfd_pkg::IDX_W+swfd_pkg::DATA_W-1:swfd_pkg::IDX_W]),
        .i_coef_center   (r_coef_center),
        .i_coef_neighbor (r_coef_neighbor),
        .i_last          (w_last_full[AW-1:0]),
        .i_right_pos     (w_rpos_full[AW-1:0]),
        .o_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .o_left_sample   (w_left),
        .o_right_sample  (w_right)
    );

    assign m_axis_tdata = {w_right, w_left};

endmodule

`default_nettype wire

@@ rtl/swfd_ctrl.sv @@
// Controller: item dispatch, sweep/clear sequencing and result hand-off.
`default_nettype none

module swfd_ctrl (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    input  wire logic [swfd_pkg::KIND_W-1:0] i_in_kind,
    output logic                          o_in_ready,
    output swfd_pkg::t_dp_cmd             o_cmd,
    input  swfd_pkg::t_dp_sts             i_sts
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TICK,
        ST_EMIT
    } t_state;

    t_state            r_state;
    swfd_pkg::t_dp_cmd r_cmd;

    assign o_in_ready = (r_state == ST_IDLE);
    assign o_cmd      = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // memories are swept to zero right after reset
            r_state           <= ST_CLEAR;
            r_cmd             <= '0;
            r_cmd.clear_start <= 1'b1;
        end else begin
            r_cmd <= '0;
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        case (i_in_kind)
                            swfd_pkg::KIND_TICK: begin
                                r_cmd.tick_start <= 1'b1;
                                r_state          <= ST_TICK;
                            end
                            swfd_pkg::KIND_LOAD: begin
                                r_cmd.load <= 1'b1;
                            end
                            swfd_pkg::KIND_CLEAR: begin
                                r_cmd.clear_start <= 1'b1;
                                r_state           <= ST_CLEAR;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_TICK: begin
                    if (!i_sts.busy) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_CLEAR: begin
                    if (!i_sts.busy) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_EMIT: begin
                    if (i_sts.out_free) begin
                        r_cmd.swap     <= 1'b1;
                        r_cmd.out_load <= 1'b1;
                        r_state        <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/swfd_dp.sv @@
// Datapath: two time-level memories, sweep pipeline, clear sweep and output register.
`default_nettype none

module swfd_dp #(
    parameter int MAX_SEGMENTS = 1024,
    parameter int AW           = $clog2(MAX_SEGMENTS)
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  swfd_pkg::t_dp_cmd                      i_cmd,
    output swfd_pkg::t_dp_sts                      o_sts,
    input  wire logic                              i_accept,
    input  wire logic [swfd_pkg::IDX_W-1:0]        i_point_index,
    input  wire logic signed [swfd_pkg::DATA_W-1:0] i_point_value,
    input  wire logic signed [swfd_pkg::COEF_W-1:0] i_coef_center,
    input  wire logic signed [swfd_pkg::COEF_W-1:0] i_coef_neighbor,
    input  wire logic [AW-1:0]                     i_last,
    input  wire logic [AW-1:0]                     i_right_pos,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [swfd_pkg::DATA_W-1:0]            o_left_sample,
    output logic [swfd_pkg::DATA_W-1:0]            o_right_sample
);

    localparam int CW = (AW > swfd_pkg::IDX_W) ? AW : swfd_pkg::IDX_W;
    localparam int DW = swfd_pkg::DATA_W;
    localparam logic signed [swfd_pkg::PSUM_W-1:0] RND_HALF =
        swfd_pkg::PSUM_W'(1) << (swfd_pkg::FRAC_SHIFT - 1);
    localparam logic [AW-1:0] ADDR_LAST = AW'(MAX_SEGMENTS - 1);
    localparam logic [AW-1:0] ADDR_ONE  = AW'(1);

    // time-level memories
    logic [DW-1:0] r_mem_a [MAX_SEGMENTS];
    logic [DW-1:0] r_mem_b [MAX_SEGMENTS];
    logic [DW-1:0] r_rd_a;
    logic [DW-1:0] r_rd_b;
    logic          w_we_a;
    logic          w_we_b;
    logic [AW-1:0] w_waddr_a;
    logic [AW-1:0] w_waddr_b;
    logic [DW-1:0] w_wdata_a;
    logic [DW-1:0] w_wdata_b;
    logic [AW-1:0] w_raddr_a;
    logic [AW-1:0] w_raddr_b;

    logic          r_cur_b;

    // load capture
    logic [CW-1:0] w_idx_ext;
    logic [AW-1:0] r_ld_addr;
    logic          r_ld_ok;
    logic [DW-1:0] r_ld_val;

    // clear sweep
    logic          r_clr_run;
    logic [AW-1:0] r_clr_addr;

    // tick sweep issue
    logic          r_run;
    logic [AW-1:0] r_addr;

    // stage 1 (memory read data)
    logic          r_s1_vld;
    logic          r_s1_zero;
    logic          r_s1_cmp;
    logic [AW-1:0] r_s1_n;
    logic signed [DW-1:0] w_cur_rd;
    logic signed [DW-1:0] w_prv_rd;
    logic signed [DW-1:0] w_rmask;
    logic signed [DW-1:0] r_win_l;
    logic signed [DW-1:0] r_win_c;

    // stage 2 (products)
    logic          r_s2_vld;
    logic [AW-1:0] r_s2_n;
    logic signed [DW-1:0] r_s2_prv;
    logic signed [swfd_pkg::PROD_W-1:0] r_p0;
    logic signed [swfd_pkg::PROD_W-1:0] r_p1;
    logic signed [swfd_pkg::PROD_W-1:0] r_p2;

    // stage 3 (partial sums)
    logic          r_s3_vld;
    logic [AW-1:0] r_s3_n;
    logic signed [DW-1:0] r_s3_prv;
    logic signed [swfd_pkg::PSUM_W-1:0] r_s01;
    logic signed [swfd_pkg::PSUM_W-1:0] r_p2h;

    // stage 4 (rounded sum)
    logic          r_s4_vld;
    logic [AW-1:0] r_s4_n;
    logic signed [DW-1:0] r_s4_prv;
    logic signed [swfd_pkg::SUM_W-1:0] w_sum;
    logic signed [swfd_pkg::RND_W-1:0] r_rnd;
    logic signed [swfd_pkg::DIFF_W-1:0] w_diff;
    logic          w_fits;
    logic [DW-1:0] w_sat;

    logic [DW-1:0] r_left;
    logic [DW-1:0] r_right;
    logic          r_out_vld;
    logic [DW-1:0] r_out_left;
    logic [DW-1:0] r_out_right;

    // ---------------- memories ----------------
    always_ff @(posedge i_clk) begin
        if (w_we_a) begin
            r_mem_a[w_waddr_a] <= w_wdata_a;
        end
        r_rd_a <= r_mem_a[w_raddr_a];
    end

    always_ff @(posedge i_clk) begin
        if (w_we_b) begin
            r_mem_b[w_waddr_b] <= w_wdata_b;
        end
        r_rd_b <= r_mem_b[w_raddr_b];
    end

    // current level is read at the issue address, previous one a point behind
    assign w_raddr_a = r_cur_b ? (r_addr - ADDR_ONE) : r_addr;
    assign w_raddr_b = r_cur_b ? r_addr : (r_addr - ADDR_ONE);

    always_comb begin
        w_we_a    = 1'b0;
        w_waddr_a = r_ld_addr;
        w_wdata_a = r_ld_val;
        w_we_b    = 1'b0;
        w_waddr_b = r_ld_addr;
        w_wdata_b = r_ld_val;
        if (r_clr_run) begin
            w_we_a    = 1'b1;
            w_waddr_a = r_clr_addr;
            w_wdata_a = '0;
            w_we_b    = 1'b1;
            w_waddr_b = r_clr_addr;
            w_wdata_b = '0;
        end else if (r_s4_vld) begin
            // new level overwrites the previous one
            if (r_cur_b) begin
                w_we_a    = 1'b1;
                w_waddr_a = r_s4_n;
                w_wdata_a = w_sat;
            end else begin
                w_we_b    = 1'b1;
                w_waddr_b = r_s4_n;
                w_wdata_b = w_sat;
            end
        end else if (i_cmd.load && r_ld_ok) begin
            w_we_a = !r_cur_b;
            w_we_b = r_cur_b;
        end
    end

    // ---------------- load capture ----------------
    assign w_idx_ext = CW'(i_point_index);

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_ld_addr <= w_idx_ext[AW-1:0];
            r_ld_val  <= i_point_value;
            r_ld_ok   <= (w_idx_ext != '0) && (w_idx_ext < CW'(i_last));
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_b    <= 1'b0;
            r_clr_run  <= 1'b0;
            r_clr_addr <= '0;
            r_run      <= 1'b0;
            r_addr     <= ADDR_ONE;
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_s3_vld   <= 1'b0;
            r_s4_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cmd.swap) begin
                r_cur_b <= !r_cur_b;
            end

            if (i_cmd.clear_start) begin
                r_clr_run  <= 1'b1;
                r_clr_addr <= '0;
            end else if (r_clr_run) begin
                if (r_clr_addr == ADDR_LAST) begin
                    r_clr_run <= 1'b0;
                end
                r_clr_addr <= r_clr_addr + ADDR_ONE;
            end

            if (i_cmd.tick_start) begin
                r_run  <= 1'b1;
                r_addr <= ADDR_ONE;
            end else if (r_run) begin
                if (r_addr == i_last) begin
                    r_run <= 1'b0;
                end
                r_addr <= r_addr + ADDR_ONE;
            end

            r_s1_vld <= r_run;
            r_s2_vld <= r_s1_vld && r_s1_cmp;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;

            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // ---------------- sweep pipeline ----------------
    assign w_cur_rd = r_cur_b ? r_rd_b : r_rd_a;
    assign w_prv_rd = r_cur_b ? r_rd_a : r_rd_b;
    // right fixed end reads as zero
    assign w_rmask  = r_s1_zero ? '0 : w_cur_rd;

    always_ff @(posedge i_clk) begin
        r_s1_zero <= (r_addr == i_last);
        r_s1_cmp  <= (r_addr != ADDR_ONE);
        r_s1_n    <= r_addr - ADDR_ONE;

        // a point is computed once its right neighbor has arrived
        if (i_cmd.tick_start) begin
            r_win_c <= '0;
        end else if (r_s1_vld) begin
            r_win_l <= r_win_c;
            r_win_c <= w_rmask;
        end

        r_p0     <= r_win_c * i_coef_center;
        r_p1     <= r_win_l * i_coef_neighbor;
        r_p2     <= w_rmask * i_coef_neighbor;
        r_s2_prv <= w_prv_rd;
        r_s2_n   <= r_s1_n;

        r_s01    <= swfd_pkg::PSUM_W'(r_p0) + swfd_pkg::PSUM_W'(r_p1);
        r_p2h    <= swfd_pkg::PSUM_W'(r_p2) + RND_HALF;
        r_s3_prv <= r_s2_prv;
        r_s3_n   <= r_s2_n;

        r_rnd    <= w_sum[swfd_pkg::SUM_W-1:swfd_pkg::FRAC_SHIFT];
        r_s4_prv <= r_s3_prv;
        r_s4_n   <= r_s3_n;

        if (r_s4_vld && (r_s4_n == ADDR_ONE)) begin
            r_left <= w_sat;
        end
        if (r_s4_vld && (r_s4_n == i_right_pos)) begin
            r_right <= w_sat;
        end

        if (i_cmd.out_load) begin
            r_out_left  <= r_left;
            r_out_right <= r_right;
        end
    end

    assign w_sum  = swfd_pkg::SUM_W'(r_s01) + swfd_pkg::SUM_W'(r_p2h);
    assign w_diff = swfd_pkg::DIFF_W'(r_rnd) - swfd_pkg::DIFF_W'(r_s4_prv);
    assign w_fits = (&w_diff[swfd_pkg::DIFF_W-1:DW-1]) || !(|w_diff[swfd_pkg::DIFF_W-1:DW-1]);
    assign w_sat  = w_fits ? w_diff[DW-1:0]
                  : (w_diff[swfd_pkg::DIFF_W-1] ? {1'b1, {(DW-1){1'b0}}}
                                                : {1'b0, {(DW-1){1'b1}}});

    // ---------------- status / outputs ----------------
    assign o_sts.busy     = i_cmd.tick_start || i_cmd.clear_start || r_clr_run || r_run
                         || r_s1_vld || r_s2_vld || r_s3_vld || r_s4_vld;
    assign o_sts.out_free = !r_out_vld || i_out_ready;

    assign o_out_valid    = r_out_vld;
    assign o_left_sample  = r_out_left;
    assign o_right_sample = r_out_right;

endmodule

`default_nettype wire

@@ tb/string_wave_fdtd_step_tb.sv @@
// Self-checking testbench for the string wave finite-difference step block.
`timescale 1ns / 1ps

module string_wave_fdtd_step_tb;
    import swfd_pkg::*;

    localparam int MAX_SEG     = 1024;
    localparam int ITEM_TARGET = 580;
    localparam int LONG_HOLD   = 3000;
    localparam int SETTLE_CYC  = MAX_SEG + 16;

    // kind and register slot that the block must ignore
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [1:0] REG_SPARE   = 2'd3;

    typedef struct packed {
        logic [31:0] right_sample;
        logic [31:0] left_sample;
    } string_samples_t;

    class string_sample_board;
        int              lvl [2][MAX_SEG];
        int              cur_sel = 0;
        int              coef_c = 0;
        int              coef_n = 0;
        logic [10:0]     nseg = 11'd1024;
        string_samples_t pending_samples[$];
        int              mismatches = 0;

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_COEF_CENTER:   coef_c = val;
                REG_COEF_NEIGHBOR: coef_n = val;
                REG_NUM_SEGMENTS:  nseg = val[10:0];
                default: ;
            endcase
        endfunction

        function int active_segs();
            if (nseg < MIN_SEGS)
                return MIN_SEGS;
            if (nseg > MAX_SEG)
                return MAX_SEG;
            return nseg;
        endfunction

        // New displacement of one interior point, saturated Q8.24
        function int step_point(int c, int l, int r, int p);
            logic signed [63:0] p0, p1, p2;
            logic signed [65:0] acc;
            logic signed [65:0] diff;
            p0 = longint'(coef_c) * longint'(c);
            p1 = longint'(coef_n) * longint'(l);
            p2 = longint'(coef_n) * longint'(r);
            acc = p0 + p1 + p2 + 66'sd134217728;
            acc = acc >>> FRAC_SHIFT;
            diff = acc - p;
            if (diff > 66'sd2147483647)
                return 32'h7FFF_FFFF;
            if (diff < -66'sd2147483648)
                return 32'h8000_0000;
            return diff[31:0];
        endfunction

        function void note_item(logic [1:0] kind, logic [9:0] idx, logic [31:0] val);
            int              last;
            int              cs;
            int              ps;
            int              l;
            int              r;
            string_samples_t s;
            last = active_segs() - 2;
            cs = cur_sel;
            ps = 1 - cur_sel;
            case (kind)
                KIND_LOAD: begin
                    if (idx > 0 && idx < last)
                        lvl[cs][idx] = val;
                end
                KIND_CLEAR: begin
                    for (int n = 0; n < MAX_SEG; n++) begin
                        lvl[0][n] = 0;
                        lvl[1][n] = 0;
                    end
                end
                KIND_TICK: begin
                    // end points read as zero whatever the store holds
                    for (int n = 1; n < last; n++) begin
                        l = (n == 1) ? 0 : lvl[cs][n-1];
                        r = (n + 1 == last) ? 0 : lvl[cs][n+1];
                        lvl[ps][n] = step_point(lvl[cs][n], l, r, lvl[ps][n]);
                    end
                    s.left_sample = lvl[ps][1];
                    s.right_sample = lvl[ps][last - 2];
                    pending_samples.push_back(s);
                    cur_sel = ps;
                end
                default: ;
            endcase
        endfunction

        function void flag(string what, logic [31:0] want, logic [31:0] got);
            mismatches++;
            if (mismatches <= 10)
                $display("%s: expected %h, got %h", what, want, got);
        endfunction

        function void check_samples(logic [63:0] data);
            string_samples_t want;
            if (pending_samples.size() == 0) begin
                flag("result with no tick pending", 'x, data[31:0]);
            end else begin
                want = pending_samples.pop_front();
                if (want.left_sample !== data[31:0])
                    flag("left_sample", want.left_sample, data[31:0]);
                if (want.right_sample !== data[63:32])
                    flag("right_sample", want.right_sample, data[63:32]);
            end
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    wire logic              s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [9:0] point_index, [41:10] point_value
    logic [KIND_W-1:0]      s_axis_tuser = '0;   // [1:0] kind
    wire logic              m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    wire logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [31:0] left_sample, [63:32] right_sample
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_AW-1:0]      paddr = '0;
    logic [APB_DW-1:0]      pwdata = '0;
    wire logic [APB_DW-1:0] prdata;
    wire logic              pready;

    string_sample_board sb = new;
    int burst_left = 0;
    int items_sent = 0;
    bit want_long_hold = 1'b0;

    string_wave_fdtd_step #(
        .MAX_SEGMENTS(MAX_SEG)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_samples(m_axis_tdata);
    end

    // Receiver: changing stall modes, plus one long hold-off on request
    initial begin : out_stall
        int mode;
        int mode_left;
        mode = 0;
        mode_left = 0;
        forever begin
            @(posedge i_clk);
            if (want_long_hold) begin
                want_long_hold = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(30, 300);
            end
            mode_left--;
            case (mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: m_axis_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    initial begin
        #12_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send_item(input logic [1:0] kind, input logic [9:0] idx,
                             input logic [31:0] val);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {6'b0, val, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(kind, idx, val);
        if (kind != KIND_UNUSED)
            items_sent++;
    endtask

    task automatic set_reg(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        sb.write_reg(idx, val);
    endtask

    // Drain all results, then give a trailing clear time to finish
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_displacement();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return $urandom();
            default: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
        endcase
    endfunction

    function automatic logic [31:0] pick_coef_extreme();
        case ($urandom_range(0, 4))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'h1000_0000;
            default: return 32'hF000_0000;
        endcase
    endfunction

    task automatic run_phase(input int n_items, input int pause_at);
        int          done_items;
        int          last;
        int          roll;
        logic [1:0]  kind;
        logic [9:0]  idx;
        done_items = 0;
        last = sb.active_segs() - 2;
        while (done_items < n_items) begin
            roll = $urandom_range(0, 99);
            idx = $urandom_range(0, 1023);
            if (roll < 45 || roll >= 94) begin
                kind = KIND_TICK;
            end else if (roll < 88) begin
                kind = KIND_LOAD;
                if ($urandom_range(0, 6) != 0)
                    idx = $urandom_range(1, last - 1);
            end else if (roll < 91) begin
                kind = KIND_CLEAR;
            end else begin
                kind = KIND_UNUSED;
            end
            send_item(kind, idx, pick_displacement());
            if (kind != KIND_UNUSED) begin
                done_items++;
                // sender waits until every pending result has been received
                if (done_items == pause_at) begin
                    s_axis_tvalid <= 1'b0;
                    do @(posedge i_clk); while (sb.pending_samples.size() != 0);
                end
            end
        end
    endtask

    initial begin
        int          phase;
        logic [10:0] nseg;
        logic [31:0] cc;
        logic [31:0] cn;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: zero coefficients, full-length string
        send_item(KIND_LOAD, 10'd1, 32'h7FFF_FFFF);
        send_item(KIND_LOAD, 10'd1021, 32'h8000_0000);
        send_item(KIND_LOAD, 10'd1022, 32'h00AB_CDEF);
        send_item(KIND_LOAD, 10'd0, 32'h0100_0000);
        send_item(KIND_TICK, 10'd0, 32'h0);
        send_item(KIND_UNUSED, 10'h3FF, 32'hFFFF_FFFF);
        send_item(KIND_TICK, 10'h3FF, 32'hFFFF_FFFF);
        settle();

        // extreme coefficients on a short string
        set_reg(REG_COEF_CENTER, 32'h7FFF_FFFF);
        set_reg(REG_COEF_NEIGHBOR, 32'h8000_0000);
        set_reg(REG_NUM_SEGMENTS, 32'd8);
        set_reg(REG_SPARE, 32'hFFFF_FFFF);
        send_item(KIND_LOAD, 10'd1, 32'h7FFF_FFFF);
        send_item(KIND_LOAD, 10'd2, 32'h8000_0000);
        send_item(KIND_LOAD, 10'd5, 32'h7FFF_FFFF);
        send_item(KIND_LOAD, 10'd6, 32'h5555_5555);
        send_item(KIND_LOAD, 10'd1023, 32'h1234_5678);
        send_item(KIND_TICK, 10'd0, 32'h0);
        send_item(KIND_TICK, 10'd0, 32'h0);
        send_item(KIND_CLEAR, 10'd0, 32'h0);
        send_item(KIND_TICK, 10'd0, 32'h0);
        send_item(KIND_LOAD, 10'd3, 32'hFFFF_FFFF);
        send_item(KIND_TICK, 10'd0, 32'h0);
        send_item(KIND_TICK, 10'd0, 32'h0);
        settle();

        for (phase = 0; items_sent < ITEM_TARGET; phase++) begin
            case (phase)
                0: nseg = 11'd0;
                1: nseg = 11'd6;
                2: nseg = 11'd2047;
                3: nseg = 11'd4;
                4: nseg = 11'd1025;
                5: nseg = 11'd1024;
                6: nseg = 11'd12;
                default: begin
                    if ($urandom_range(0, 19) == 0)
                        nseg = $urandom_range(201, 1024);
                    else if ($urandom_range(0, 5) == 0)
                        nseg = $urandom_range(41, 200);
                    else
                        nseg = $urandom_range(5, 40);
                end
            endcase
            case (phase % 4)
                1: begin
                    cc = $urandom();
                    cn = $urandom();
                end
                2: begin
                    cc = pick_coef_extreme();
                    cn = pick_coef_extreme();
                end
                default: begin
                    // stable scheme: Courant number squared at most one
                    cn = $urandom_range(0, 32'h1000_0000);
                    cc = 32'h2000_0000 - 2 * cn;
                end
            endcase
            set_reg(REG_COEF_CENTER, cc);
            set_reg(REG_COEF_NEIGHBOR, cn);
            set_reg(REG_NUM_SEGMENTS, {21'b0, nseg});
            if (phase == 6) begin
                want_long_hold = 1'b1;
                burst_left = 60;
            end
            run_phase(sb.active_segs() > 200 ? 12 : 45, phase == 7 ? 20 : -1);
            settle();
        end

        if (sb.mismatches == 0 && sb.pending_samples.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
